// ===== hdl/kss_pkg.sv =====
// Shared constants, beat types and chain control types for the k-th smallest selector.
package kss_pkg;

    // Capacity of the sorted chain and derived widths.
    localparam int MAX_ITEMS = 256;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 32;
    localparam int RANK_W    = 13;

    // Input beat: one element of the set.
    typedef struct packed {
        logic signed [VAL_W-1:0]  sample_value;
        logic                     last_item;
        logic [RANK_W-1:0]        rank_k;
    } in_beat_t;

    // Output beat: the selected element and its flags.
    typedef struct packed {
        logic signed [VAL_W-1:0]  kth_value;
        logic                     rank_error;
        logic                     overflow;
    } out_beat_t;

    // Contents of one chain cell as seen by its neighbors.
    typedef struct packed {
        logic                     valid;
        logic signed [VAL_W-1:0]  value;
    } cell_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                     ins;
        logic                     shift;
        logic                     clr;
        logic signed [VAL_W-1:0]  value;
    } ctl_t;

endpackage

// ===== hdl/kss_in_if.sv =====
// Valid/ready channel that carries input beats.
interface kss_in_if;
    import kss_pkg::*;

    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/kss_out_if.sv =====
// Valid/ready channel that carries result beats.
interface kss_out_if;
    import kss_pkg::*;

    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/kth_smallest_select.sv =====
// Top level of the k-th smallest selector: load control, rank walk and result register.
//
//  channel   dir  beat contents                              accepted when
//  samples   in   sample_value, last_item, rank_k            valid && ready
//  results   out  kth_value, rank_error, overflow            valid && ready
//
// Each element is inserted into the sorted cell chain as it is accepted, while there is room.
// On the marked last beat the chain then shifts toward its head until the k-th smallest
// element is there and loads the result register once it is free; the input is not ready
// until that load. A bad rank skips the walk and loads a zero result with the error flag.
// A stalled result beat holds the walk at its end.
// Reset empties the chain at once; no clearing pass is needed.
module kth_smallest_select (
    input logic  clk,
    input logic  rst_n,
    kss_in_if.sink    samples,
    kss_out_if.source results
);
    import kss_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEL  = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             err_reg, err_next;
    logic             ovfo_reg, ovfo_next;
    logic [IDX_W-1:0] cd_reg, cd_next;
    logic             out_valid_reg, out_valid_next;
    out_beat_t        out_data_reg, out_data_next;

    ctl_t             ctl;
    cell_t            head;
    logic             accept;
    logic             room;
    logic [CNT_W-1:0] cnt_after;
    logic             bad_rank;
    logic             out_free;
    logic             load;

    kss_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .head  (head)
    );

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign room          = (cnt_reg < CNT_W'(MAX_ITEMS));
    assign cnt_after     = cnt_reg + CNT_W'(room);
    assign bad_rank      = (samples.data.rank_k == '0)
                        || (32'(samples.data.rank_k) > 32'(cnt_after));
    assign out_free      = !out_valid_reg || results.ready;

    // Control: load elements, then walk the chain to the wanted rank.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        err_next   = err_reg;
        ovfo_next  = ovfo_reg;
        cd_next    = cd_reg;
        load       = 1'b0;
        ctl.ins    = accept && room;
        ctl.shift  = 1'b0;
        ctl.clr    = 1'b0;
        ctl.value  = samples.data.sample_value;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (samples.data.last_item)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        err_next   = bad_rank;
                        ovfo_next  = ovf_reg || !room;
                        cd_next    = bad_rank ? '0
                                   : IDX_W'(samples.data.rank_k - RANK_W'(1));
                        state_next = ST_SEL;
                    end
                    else
                    begin
                        cnt_next = cnt_after;
                        ovf_next = ovf_reg || !room;
                    end
                end
            end
            ST_SEL:
            begin
                if (cd_reg != '0)
                begin
                    ctl.shift = 1'b1;
                    cd_next   = cd_reg - IDX_W'(1);
                end
                else if (out_free)
                begin
                    load       = 1'b1;
                    ctl.clr    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register parts the chain from the output channel.
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !results.ready;
        if (load)
        begin
            out_valid_next           = 1'b1;
            out_data_next.kth_value  = err_reg ? '0 : head.value;
            out_data_next.rank_error = err_reg;
            out_data_next.overflow   = ovfo_reg;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            err_reg       <= 1'b0;
            ovfo_reg      <= 1'b0;
            cd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            err_reg       <= err_next;
            ovfo_reg      <= ovfo_next;
            cd_reg        <= cd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // The fill count never passes the chain capacity.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count above capacity");

    // A dropped element can only happen with a full chain.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (cnt_reg == CNT_W'(MAX_ITEMS)))
        else $error("overflow flagged with room left");

    // With a good rank the walk always keeps a real element at the head.
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL && !err_reg) |-> head.valid)
        else $error("rank walk ran past the held elements");

    // Loading a result empties the chain for the next set.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (!head.valid && cnt_reg == '0))
        else $error("chain not cleared after a result");

endmodule

// ===== hdl/kss_cell.sv =====
// One cell of the sorted insertion chain.
module kss_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  kss_pkg::ctl_t  ctl,
    input  kss_pkg::cell_t prev_cell,
    input  logic           prev_gt,
    input  kss_pkg::cell_t next_cell,
    output kss_pkg::cell_t held_cell,
    output logic           gt
);
    import kss_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;

    // This cell sorts after the incoming value (empty cells always do).
    assign gt        = !valid_reg || (value_reg > ctl.value);
    assign held_cell = '{valid: valid_reg, value: value_reg};

    // Insert moves the tail one place right; shift moves everything left; clear empties the cell.
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_next = next_cell.valid;
            value_next = next_cell.value;
        end
        else if (ctl.ins && gt)
        begin
            if (prev_gt)
            begin
                valid_next = prev_cell.valid;
                value_next = prev_cell.value;
            end
            else
            begin
                valid_next = 1'b1;
                value_next = ctl.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== hdl/kss_chain.sv =====
// Row of cells that keeps the held elements in ascending order.
module kss_chain (
    input  logic           clk,
    input  logic           rst_n,
    input  kss_pkg::ctl_t  ctl,
    output kss_pkg::cell_t head
);
    import kss_pkg::*;

    cell_t cells [MAX_ITEMS];
    logic  gts   [MAX_ITEMS];

    // Each cell looks at its left neighbor for insertion and its right one for shifting.
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        cell_t prev_c;
        logic  prev_g;
        cell_t next_c;

        if (i == 0)
        begin : g_first
            assign prev_c = '0;
            assign prev_g = 1'b0;
        end
        else
        begin : g_mid
            assign prev_c = cells[i-1];
            assign prev_g = gts[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_last
            assign next_c = '0;
        end
        else
        begin : g_inner
            assign next_c = cells[i+1];
        end

        kss_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .prev_cell (prev_c),
            .prev_gt   (prev_g),
            .next_cell (next_c),
            .held_cell (cells[i]),
            .gt        (gts[i])
        );
    end

    assign head = cells[0];

endmodule
